// ----- rtl/tfn_pkg.sv -----
// Package for the triangle face normal unit: widths, stage counts, types.
// No dependencies.
package tfn_pkg;

   localparam int CoordWidth     = 16;
   localparam int NormalFracBits = 14;
   localparam int EdgeWidth      = CoordWidth + 1;
   localparam int ProdWidth      = 2 * EdgeWidth;
   localparam int CrossWidth     = ProdWidth + 1;
   localparam int MagWidth       = CrossWidth - 1;
   localparam int SqWidth        = 2 * MagWidth;
   localparam int SumWidth       = SqWidth + 2;
   localparam int QWidth         = NormalFracBits + 1;
   localparam int AccWidth       = SumWidth + 2 * NormalFracBits + 6;
   localparam int OutWidth       = 16;
   localparam int NumSteps       = QWidth;

   typedef logic signed [EdgeWidth-1:0]  edge_type;
   typedef logic signed [ProdWidth-1:0]  prod_type;
   typedef logic        [MagWidth-1:0]   mag_type;
   typedef logic        [SqWidth-1:0]    sq_type;
   typedef logic        [SumWidth-1:0]   sum_type;
   typedef logic signed [AccWidth-1:0]   acc_type;
   typedef logic        [QWidth-1:0]     quot_type;
   typedef logic signed [OutWidth-1:0]   norm_type;

endpackage

// ----- rtl/triangle_face_normal_unit.sv -----
// Throughput one request per cycle while the result port is not stalled.
// Pipeline: edges, products, cross/magnitude, squares, sum, 15 rounding-search steps, output.
// A stall at the result port holds every stage; nothing is lost or repeated.
// Synchronous active-high reset clears the valid bits only; data registers are not reset.
// Depends on tfn_pkg.
module triangle_face_normal_unit import tfn_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_a_x,
   input  logic [15:0] req_a_y,
   input  logic [15:0] req_a_z,
   input  logic [15:0] req_b_x,
   input  logic [15:0] req_b_y,
   input  logic [15:0] req_b_z,
   input  logic [15:0] req_c_x,
   input  logic [15:0] req_c_y,
   input  logic [15:0] req_c_z,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_normal_x,
   output logic [15:0] rsp_normal_y,
   output logic [15:0] rsp_normal_z,
   output logic        rsp_degenerate
);

   logic adv;
   logic out_valid_ff;

   assign adv       = !out_valid_ff || rsp_ready;
   assign req_ready = adv;

   // stage 1: edges
   logic     v1_ff;
   edge_type d1_ff [3];
   edge_type d2_ff [3];
   edge_type a_in  [3];
   edge_type b_in  [3];
   edge_type c_in  [3];

   always_comb begin
      a_in[0] = EdgeWidth'($signed(req_a_x[CoordWidth-1:0]));
      a_in[1] = EdgeWidth'($signed(req_a_y[CoordWidth-1:0]));
      a_in[2] = EdgeWidth'($signed(req_a_z[CoordWidth-1:0]));
      b_in[0] = EdgeWidth'($signed(req_b_x[CoordWidth-1:0]));
      b_in[1] = EdgeWidth'($signed(req_b_y[CoordWidth-1:0]));
      b_in[2] = EdgeWidth'($signed(req_b_z[CoordWidth-1:0]));
      c_in[0] = EdgeWidth'($signed(req_c_x[CoordWidth-1:0]));
      c_in[1] = EdgeWidth'($signed(req_c_y[CoordWidth-1:0]));
      c_in[2] = EdgeWidth'($signed(req_c_z[CoordWidth-1:0]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
      end
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            d1_ff[i] <= b_in[i] - a_in[i];
            d2_ff[i] <= c_in[i] - a_in[i];
         end
      end
   end

   // stage 2: six products, pairs (pos, neg) per component
   logic     v2_ff;
   prod_type pp_ff [3];
   prod_type pn_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
      if (adv) begin
         pp_ff[0] <= d1_ff[1] * d2_ff[2];
         pn_ff[0] <= d1_ff[2] * d2_ff[1];
         pp_ff[1] <= d1_ff[2] * d2_ff[0];
         pn_ff[1] <= d1_ff[0] * d2_ff[2];
         pp_ff[2] <= d1_ff[0] * d2_ff[1];
         pn_ff[2] <= d1_ff[1] * d2_ff[0];
      end
   end

   // stage 3: cross product, sign and magnitude
   logic                         v3_ff;
   mag_type                      mag_ff [3];
   logic [2:0]                   neg3_ff;
   logic                         degen3_ff;
   logic signed [CrossWidth-1:0] cross_in [3];
   mag_type                      mag_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cross_in[i] = CrossWidth'(pp_ff[i]) - CrossWidth'(pn_ff[i]);
         mag_in[i]   = cross_in[i][CrossWidth-1] ? MagWidth'(-cross_in[i])
                                                 : MagWidth'(cross_in[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            mag_ff[i]  <= mag_in[i];
            neg3_ff[i] <= cross_in[i][CrossWidth-1];
         end
         degen3_ff <= (cross_in[0] == '0) && (cross_in[1] == '0) && (cross_in[2] == '0);
      end
   end

   // stage 4: squares
   logic       v4_ff;
   sq_type     sq_ff [3];
   logic [2:0] neg4_ff;
   logic       degen4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= v3_ff;
      end
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= mag_ff[i] * mag_ff[i];
         end
         neg4_ff   <= neg3_ff;
         degen4_ff <= degen3_ff;
      end
   end

   // Rounding search: largest q with (2q-1)^2 * s <= m^2 * 2^(2F+2), one bit per stage.
   // Tracks P = (2q-1)^2 * s and Q = (2q-1) * s so each trial is adds and shifts only.
   logic       sv_ff    [NumSteps+1];
   sum_type    ss_ff    [NumSteps+1];
   acc_type    sp_ff    [NumSteps+1][3];
   acc_type    sq2_ff   [NumSteps+1][3];
   quot_type   sqt_ff   [NumSteps+1][3];
   acc_type    sb_ff    [NumSteps+1][3];
   logic [2:0] sneg_ff  [NumSteps+1];
   logic       sdeg_ff  [NumSteps+1];

   // stage 5: sum of squares and per-lane bound m^2 * 2^(2F+2); seeds the search at q = 0
   sum_type sum_in;
   acc_type sum_acc_in;

   always_comb begin
      sum_in     = SumWidth'(sq_ff[0]) + SumWidth'(sq_ff[1]) + SumWidth'(sq_ff[2]);
      sum_acc_in = AccWidth'(sum_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff[0] <= 1'b0;
      end else if (adv) begin
         sv_ff[0] <= v4_ff;
      end
      if (adv) begin
         ss_ff[0]   <= sum_in;
         sneg_ff[0] <= neg4_ff;
         sdeg_ff[0] <= degen4_ff;
         for (int i = 0; i < 3; i++) begin
            sp_ff[0][i]  <= sum_acc_in;
            sq2_ff[0][i] <= -sum_acc_in;
            sqt_ff[0][i] <= '0;
            sb_ff[0][i]  <= AccWidth'(sq_ff[i]) <<< (2 * NormalFracBits + 2);
         end
      end
   end

   for (genvar g = 0; g < NumSteps; g++) begin : g_step
      localparam int J = NumSteps - 1 - g;
      acc_type trial [3];
      acc_type sacc;

      always_comb begin
         sacc = AccWidth'(ss_ff[g]);
         for (int i = 0; i < 3; i++) begin
            trial[i] = sp_ff[g][i] + (sq2_ff[g][i] <<< (J + 2)) + (sacc <<< (2 * J + 2));
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[g+1] <= 1'b0;
         end else if (adv) begin
            sv_ff[g+1] <= sv_ff[g];
         end
         if (adv) begin
            ss_ff[g+1]   <= ss_ff[g];
            sneg_ff[g+1] <= sneg_ff[g];
            sdeg_ff[g+1] <= sdeg_ff[g];
            for (int i = 0; i < 3; i++) begin
               sb_ff[g+1][i] <= sb_ff[g][i];
               if (trial[i] <= sb_ff[g][i]) begin
                  sp_ff[g+1][i]  <= trial[i];
                  sq2_ff[g+1][i] <= sq2_ff[g][i] + (sacc <<< (J + 1));
                  sqt_ff[g+1][i] <= sqt_ff[g][i] | (QWidth'(1) << J);
               end else begin
                  sp_ff[g+1][i]  <= sp_ff[g][i];
                  sq2_ff[g+1][i] <= sq2_ff[g][i];
                  sqt_ff[g+1][i] <= sqt_ff[g][i];
               end
            end
         end
      end
   end

   // output stage: sign, zero on degenerate
   norm_type norm_ff [3];
   logic     degen_ff;
   norm_type norm_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (sdeg_ff[NumSteps]) begin
            norm_in[i] = '0;
         end else if (sneg_ff[NumSteps][i]) begin
            norm_in[i] = -OutWidth'(sqt_ff[NumSteps][i]);
         end else begin
            norm_in[i] = OutWidth'(sqt_ff[NumSteps][i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= sv_ff[NumSteps];
      end
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            norm_ff[i] <= norm_in[i];
         end
         degen_ff <= sdeg_ff[NumSteps];
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_normal_x   = norm_ff[0];
   assign rsp_normal_y   = norm_ff[1];
   assign rsp_normal_z   = norm_ff[2];
   assign rsp_degenerate = degen_ff;

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_normal_x == '0 && rsp_normal_y == '0 && rsp_normal_z == '0)
      else $error("degenerate result with nonzero normal");

   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $signed(rsp_normal_x) <= 16384 && $signed(rsp_normal_x) >= -16384
                 && $signed(rsp_normal_z) <= 16384 && $signed(rsp_normal_z) >= -16384)
      else $error("normal component out of range");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_normal_y))
      else $error("result dropped during stall");

   a_ready_follows: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with empty output");

endmodule
